// ----- hdl/perlin_noise_3d_octaves_assert.svh -----
// ----------------------------------------------------------------------------
// perlin noise assertion macros
// shared property forms for the noise block checks
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_3D_OCTAVES_ASSERT_SVH
`define PERLIN_NOISE_3D_OCTAVES_ASSERT_SVH

// same-cycle implication
`define PN3_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PN3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pn3_pkg.sv -----
// ----------------------------------------------------------------------------
// pn3_pkg
// shared constants, types and helpers of the 3d gradient noise block
// ----------------------------------------------------------------------------
package pn3_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int TABLE_DEPTH = 256;
   localparam int MAX_OCTAVES = 8;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W = 8;
   localparam int COORD_W = 24;
   localparam int LV_W    = FRAC_BITS + 3;
   localparam int FADE_W  = FRAC_BITS + 1;
   localparam int OUT_W   = FRAC_BITS + 3;
   localparam int SUM_W   = FRAC_BITS + 6;
   localparam int CFG_W   = 4;
   localparam int OCT_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int CNT_W   = 4;
   localparam int ONE     = 1 << FRAC_BITS;

   localparam int REQ_DATA_W = 2 * ENTRY_W + 3 * COORD_W;
   localparam int RSP_DATA_W = ((OUT_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // register word index
   localparam logic CSR_OCTAVE_COUNT = 1'b0;

   // sequencer step marks
   localparam logic [CNT_W-1:0] HASH_LAST   = 4'd14;
   localparam logic [CNT_W-1:0] GRAD_FIRST  = 4'd7;
   localparam logic [CNT_W-1:0] LERP_U_LAST = 4'd3;
   localparam logic [CNT_W-1:0] LERP_V_LAST = 4'd5;
   localparam logic [CNT_W-1:0] LERP_LAST   = 4'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_LERP,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [ENTRY_W-1:0] data;
   } perm_wr_type;

   // 12-direction gradient dot product
   function automatic logic signed [LV_W-1:0] grad_fx(
      input logic [3:0]             h,
      input logic signed [LV_W-1:0] x,
      input logic signed [LV_W-1:0] y,
      input logic signed [LV_W-1:0] z
   );
      logic signed [LV_W-1:0] u;
      logic signed [LV_W-1:0] v;
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

endpackage

// ----- hdl/pn3_perm_ram.sv -----
// ----------------------------------------------------------------------------
// pn3_perm_ram
// permutation table, one write port and one registered read port
// ----------------------------------------------------------------------------
module pn3_perm_ram
   import pn3_pkg::*;
(
   input  logic               clock,
   input  perm_wr_type        wr,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/pn3_fade.sv -----
// ----------------------------------------------------------------------------
// pn3_fade
// three-stage fade curve 6t^5 - 15t^4 + 10t^3 in fixed point
// ----------------------------------------------------------------------------
module pn3_fade
   import pn3_pkg::*;
(
   input  logic                 clock,
   input  logic [FRAC_BITS-1:0] t,
   output logic [FADE_W-1:0]    fade
);

   localparam int Q_W = FRAC_BITS + 4;
   localparam int P_W = FRAC_BITS + Q_W;
   localparam int S_W = 2 * FRAC_BITS;

   logic [Q_W-1:0]       mul_in;
   logic [P_W-1:0]       q_prod;
   logic [S_W-1:0]       c_prod;
   logic [S_W-1:0]       d_prod;
   logic [P_W-1:0]       f_prod;
   logic [Q_W-1:0]       b_in;
   logic [Q_W-1:0]       q_ff;
   logic [FRAC_BITS-1:0] c_ff;
   logic [FRAC_BITS-1:0] t_ff;
   logic [Q_W-1:0]       b_ff;
   logic [FRAC_BITS-1:0] d_ff;
   logic [FADE_W-1:0]    fade_ff;

   // stage one: t*(15-6t) and t*t
   assign mul_in = Q_W'(15 * ONE) - (Q_W'(t) * Q_W'(6));
   assign q_prod = P_W'(t) * P_W'(mul_in);
   assign c_prod = S_W'(t) * S_W'(t);

   // stage two: 10 - q and t^3
   assign b_in   = Q_W'(10 * ONE) - q_ff;
   assign d_prod = S_W'(c_ff) * S_W'(t_ff);

   // stage three: final product
   assign f_prod = P_W'(d_ff) * P_W'(b_ff);

   always_ff @(posedge clock) begin
      q_ff    <= q_prod[FRAC_BITS +: Q_W];
      c_ff    <= c_prod[FRAC_BITS +: FRAC_BITS];
      t_ff    <= t;
      b_ff    <= b_in;
      d_ff    <= d_prod[FRAC_BITS +: FRAC_BITS];
      fade_ff <= f_prod[FRAC_BITS +: FADE_W];
   end

   assign fade = fade_ff;

endmodule

// ----- hdl/perlin_noise_3d_octaves.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves
// improved 3d gradient noise with octave summing
// ----------------------------------------------------------------------------
// req beats carry a kind in req_tuser: a load writes one permutation byte,
// an evaluate gives three Q8.16 coordinates. rsp gives one Q2.16 noise value
// per evaluate, nothing for a load. csr word 0 holds the octave count.
// an evaluate runs each octave in turn and then loads the output register:
// each octave makes 14 chained reads through the one registered read port
// of the permutation memory, then 7 lerps through one shared multiplier and
// an accumulate step.
// req_tready is high only while no evaluate is in flight, so evaluates run
// one at a time; a finished value waits in the output register while the
// next beat is taken. a stalled rsp holds the block in its output step.
// reset clears control and sets the octave count to 1; the permutation
// table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module perlin_noise_3d_octaves
   import pn3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index, entry_value, x_coord, y_coord, z_coord
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // noise_value, zero padded
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   `include "perlin_noise_3d_octaves_assert.svh"

   localparam int X_LSB  = IDX_W + ENTRY_W;
   localparam int Y_LSB  = X_LSB + COORD_W;
   localparam int Z_LSB  = Y_LSB + COORD_W;
   localparam int PROD_W = FADE_W + LV_W + 2;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(4 * ONE - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(4 * ONE);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [OCT_W-1:0]         oct_ff, oct_in;
   logic [CFG_W-1:0]         octave_ff;
   logic [COORD_W-1:0]       xc_ff, yc_ff, zc_ff;
   logic [IDX_W-1:0]         a_ff, b_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [LV_W-1:0]   gq_ff [8];
   logic signed [LV_W-1:0]   uq_ff [4];
   logic signed [LV_W-1:0]   vq_ff [2];
   logic signed [LV_W-1:0]   noise_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     rsp_valid_ff;
   logic [OUT_W-1:0]         rsp_data_ff;

   logic                     accept;
   logic                     eval_go;
   logic                     out_free;
   logic                     out_load;
   logic                     oct_last;
   logic [CFG_W-1:0]         n_last;
   logic [IDX_W-1:0]         rd_addr;
   logic [ENTRY_W-1:0]       rd_data;
   perm_wr_type              perm_wr;
   logic [FADE_W-1:0]        fade_u, fade_v, fade_w;
   logic [IDX_W-1:0]         xi, yi, zi;
   logic [2:0]               corner;
   logic signed [LV_W-1:0]   x0, y0, z0, x1, y1, z1;
   logic signed [LV_W-1:0]   grad_new;
   logic signed [LV_W-1:0]   la, lb, lnew;
   logic [FADE_W-1:0]        lt;
   logic signed [LV_W:0]     ldiff;
   logic signed [PROD_W-1:0] lprod;
   logic signed [SUM_W-1:0]  sum_sat;

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign eval_go    = accept && (req_tuser == REQ_EVAL);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // table write port
   assign perm_wr.en   = accept && (req_tuser == REQ_LOAD);
   assign perm_wr.addr = req_tdata[IDX_W-1:0];
   assign perm_wr.data = req_tdata[IDX_W +: ENTRY_W];

   pn3_perm_ram u_perm_ram (
      .clock   (clock),
      .wr      (perm_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // fade curves follow the fractions, settled long before the lerps
   pn3_fade u_fade_x (.clock(clock), .t(xc_ff[FRAC_BITS-1:0]), .fade(fade_u));
   pn3_fade u_fade_y (.clock(clock), .t(yc_ff[FRAC_BITS-1:0]), .fade(fade_v));
   pn3_fade u_fade_z (.clock(clock), .t(zc_ff[FRAC_BITS-1:0]), .fade(fade_w));

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff <= CFG_W'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == CSR_OCTAVE_COUNT) begin
         octave_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_OCTAVE_COUNT) ? CSR_DATA_W'(octave_ff) : '0;

   // last octave index after clamping the count
   always_comb begin
      if (octave_ff == '0) begin
         n_last = '0;
      end else if (octave_ff > CFG_W'(MAX_OCTAVES)) begin
         n_last = CFG_W'(MAX_OCTAVES - 1);
      end else begin
         n_last = octave_ff - CFG_W'(1);
      end
   end

   assign oct_last = (CFG_W'(oct_ff) == n_last);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (eval_go) state_in = ST_HASH;
         ST_HASH: if (cnt_ff == HASH_LAST) state_in = ST_LERP;
         ST_LERP: if (cnt_ff == LERP_LAST) state_in = ST_ACC;
         ST_ACC:  state_in = oct_last ? ST_OUT : ST_HASH;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // step and octave counters
   always_comb begin
      cnt_in = '0;
      oct_in = oct_ff;
      case (state_ff)
         ST_IDLE: oct_in = '0;
         ST_HASH: cnt_in = (cnt_ff == HASH_LAST) ? '0 : cnt_ff + CNT_W'(1);
         ST_LERP: cnt_in = (cnt_ff == LERP_LAST) ? '0 : cnt_ff + CNT_W'(1);
         ST_ACC:  if (!oct_last) oct_in = oct_ff + OCT_W'(1);
         default: cnt_in = '0;
      endcase
   end

   // outputs of the sequencer
   assign xi = xc_ff[FRAC_BITS +: IDX_W];
   assign yi = yc_ff[FRAC_BITS +: IDX_W];
   assign zi = zc_ff[FRAC_BITS +: IDX_W];

   always_comb begin
      out_load = (state_ff == ST_OUT) && out_free;
      rd_addr  = '0;
      case (cnt_ff)
         4'd0:    rd_addr = xi;
         4'd1:    rd_addr = xi + IDX_W'(1);
         4'd2:    rd_addr = a_ff;
         4'd3:    rd_addr = a_ff + IDX_W'(1);
         4'd4:    rd_addr = b_ff;
         4'd5:    rd_addr = b_ff + IDX_W'(1);
         4'd6:    rd_addr = aa_ff;
         4'd7:    rd_addr = ba_ff;
         4'd8:    rd_addr = ab_ff;
         4'd9:    rd_addr = bb_ff;
         4'd10:   rd_addr = aa_ff + IDX_W'(1);
         4'd11:   rd_addr = ba_ff + IDX_W'(1);
         4'd12:   rd_addr = ab_ff + IDX_W'(1);
         4'd13:   rd_addr = bb_ff + IDX_W'(1);
         default: rd_addr = '0;
      endcase
   end

   // corner offsets and gradient of the byte just read
   assign x0       = LV_W'(xc_ff[FRAC_BITS-1:0]);
   assign y0       = LV_W'(yc_ff[FRAC_BITS-1:0]);
   assign z0       = LV_W'(zc_ff[FRAC_BITS-1:0]);
   assign x1       = x0 - LV_W'(ONE);
   assign y1       = y0 - LV_W'(ONE);
   assign z1       = z0 - LV_W'(ONE);
   assign corner   = 3'(cnt_ff - GRAD_FIRST);
   assign grad_new = grad_fx(rd_data[3:0], corner[0] ? x1 : x0,
                             corner[1] ? y1 : y0, corner[2] ? z1 : z0);

   // shared lerp unit
   always_comb begin
      if (cnt_ff <= LERP_U_LAST) begin
         la = gq_ff[0];
         lb = gq_ff[1];
         lt = fade_u;
      end else if (cnt_ff <= LERP_V_LAST) begin
         la = uq_ff[0];
         lb = uq_ff[1];
         lt = fade_v;
      end else begin
         la = vq_ff[0];
         lb = vq_ff[1];
         lt = fade_w;
      end
   end

   assign ldiff = (LV_W + 1)'(lb) - (LV_W + 1)'(la);
   assign lprod = PROD_W'(signed'({1'b0, lt})) * PROD_W'(ldiff);
   assign lnew  = la + LV_W'(lprod >>> FRAC_BITS);

   // saturation of the octave sum
   always_comb begin
      if (sum_ff > SAT_HI) begin
         sum_sat = SAT_HI;
      end else if (sum_ff < SAT_LO) begin
         sum_sat = SAT_LO;
      end else begin
         sum_sat = sum_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         oct_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         oct_ff   <= oct_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (eval_go) begin
         xc_ff  <= req_tdata[X_LSB +: COORD_W];
         yc_ff  <= req_tdata[Y_LSB +: COORD_W];
         zc_ff  <= req_tdata[Z_LSB +: COORD_W];
         sum_ff <= '0;
      end
      if (state_ff == ST_HASH) begin
         case (cnt_ff)
            4'd1:    a_ff  <= rd_data + yi;
            4'd2:    b_ff  <= rd_data + yi;
            4'd3:    aa_ff <= rd_data + zi;
            4'd4:    ab_ff <= rd_data + zi;
            4'd5:    ba_ff <= rd_data + zi;
            4'd6:    bb_ff <= rd_data + zi;
            default: a_ff  <= a_ff;
         endcase
         // gradients shift in, first corner ends at the head
         if (cnt_ff >= GRAD_FIRST) begin
            for (int i = 0; i < 7; i++) begin
               gq_ff[i] <= gq_ff[i+1];
            end
            gq_ff[7] <= grad_new;
         end
      end
      if (state_ff == ST_LERP) begin
         if (cnt_ff <= LERP_U_LAST) begin
            for (int i = 0; i < 6; i++) begin
               gq_ff[i] <= gq_ff[i+2];
            end
            for (int i = 0; i < 3; i++) begin
               uq_ff[i] <= uq_ff[i+1];
            end
            uq_ff[3] <= lnew;
         end else if (cnt_ff <= LERP_V_LAST) begin
            uq_ff[0] <= uq_ff[2];
            uq_ff[1] <= uq_ff[3];
            vq_ff[0] <= vq_ff[1];
            vq_ff[1] <= lnew;
         end else begin
            noise_ff <= lnew;
         end
      end
      // weight the octave and double the coordinates
      if (state_ff == ST_ACC) begin
         sum_ff <= sum_ff + (SUM_W'(noise_ff) >>> oct_ff);
         xc_ff  <= {xc_ff[COORD_W-2:0], 1'b0};
         yc_ff  <= {yc_ff[COORD_W-2:0], 1'b0};
         zc_ff  <= {zc_ff[COORD_W-2:0], 1'b0};
      end
      if (out_load) begin
         rsp_data_ff <= OUT_W'(sum_sat);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // checks
   `PN3_ASSERT_NOW(a_first_octave_from_accept, clock, reset,
      state_ff == ST_HASH && cnt_ff == '0 && oct_ff == '0, $past(eval_go),
      "first octave started without an evaluate beat")
   `PN3_ASSERT_NEXT(a_last_octave_to_out, clock, reset,
      state_ff == ST_ACC && oct_last, state_ff == ST_OUT,
      "last octave did not move to output")
   `PN3_ASSERT_NOW(a_result_from_out, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == ST_OUT),
      "result raised outside the output step")

endmodule

// ----- tb/noise_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_checker
// watches the request, result and register channels of the noise block,
// keeps its own copy of the permutation table and octave count, predicts
// the octave sum of every evaluate beat and compares result beats in order
// ----------------------------------------------------------------------------
module noise_checker
   import pn3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    noise_pending,
   output int                    fail_count
);

   localparam longint UNIT = longint'(1) << FRAC_BITS;

   logic [ENTRY_W-1:0]        perm_shadow [TABLE_DEPTH];
   logic [CFG_W-1:0]          octaves_shadow;
   logic signed [OUT_W-1:0]   noise_queue [$];

   function automatic longint perm_at(input int idx);
      return longint'(perm_shadow[IDX_W'(idx)]);
   endfunction

   // 6t^5 - 15t^4 + 10t^3 with truncation after every product
   function automatic longint fade_curve(input longint t);
      longint q, b, c, d;
      q = (t * (15 * UNIT - 6 * t)) >>> FRAC_BITS;
      b = 10 * UNIT - q;
      c = (t * t) >>> FRAC_BITS;
      d = (c * t) >>> FRAC_BITS;
      return (d * b) >>> FRAC_BITS;
   endfunction

   // arithmetic shift of a signed longint floors
   function automatic longint blend(input longint t, input longint a, input longint b);
      return a + ((t * (b - a)) >>> FRAC_BITS);
   endfunction

   function automatic longint corner_dot(input longint hash, input longint x,
                                         input longint y, input longint z);
      longint h, u, v;
      h = hash & 15;
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic longint lattice_noise(input logic [COORD_W-1:0] xc,
                                            input logic [COORD_W-1:0] yc,
                                            input logic [COORD_W-1:0] zc);
      int     xi, yi, zi, a, aa, ab, b, ba, bb;
      longint x, y, z, u, v, w, x1, y1, z1, l0, l1;
      xi = int'(xc[COORD_W-1:FRAC_BITS]);
      yi = int'(yc[COORD_W-1:FRAC_BITS]);
      zi = int'(zc[COORD_W-1:FRAC_BITS]);
      x = longint'(xc[FRAC_BITS-1:0]);
      y = longint'(yc[FRAC_BITS-1:0]);
      z = longint'(zc[FRAC_BITS-1:0]);
      u = fade_curve(x);
      v = fade_curve(y);
      w = fade_curve(z);
      a  = int'((perm_at(xi) + yi) & 255);
      aa = int'((perm_at(a) + zi) & 255);
      ab = int'((perm_at(a + 1) + zi) & 255);
      b  = int'((perm_at(xi + 1) + yi) & 255);
      ba = int'((perm_at(b) + zi) & 255);
      bb = int'((perm_at(b + 1) + zi) & 255);
      x1 = x - UNIT;
      y1 = y - UNIT;
      z1 = z - UNIT;
      l0 = blend(v,
         blend(u, corner_dot(perm_at(aa), x, y, z), corner_dot(perm_at(ba), x1, y, z)),
         blend(u, corner_dot(perm_at(ab), x, y1, z), corner_dot(perm_at(bb), x1, y1, z)));
      l1 = blend(v,
         blend(u, corner_dot(perm_at(aa + 1), x, y, z1),
                  corner_dot(perm_at(ba + 1), x1, y, z1)),
         blend(u, corner_dot(perm_at(ab + 1), x, y1, z1),
                  corner_dot(perm_at(bb + 1), x1, y1, z1)));
      return blend(w, l0, l1);
   endfunction

   // weighted octave sum, saturated to Q2.16
   function automatic logic signed [OUT_W-1:0] octave_sum(input logic [COORD_W-1:0] xc,
                                                         input logic [COORD_W-1:0] yc,
                                                         input logic [COORD_W-1:0] zc);
      int     n;
      longint total;
      total = 0;
      n = (octaves_shadow == '0) ? 1 :
          (int'(octaves_shadow) > MAX_OCTAVES) ? MAX_OCTAVES : int'(octaves_shadow);
      for (int i = 0; i < n; i++) begin
         total += lattice_noise(xc, yc, zc) >>> i;
         xc = xc << 1;
         yc = yc << 1;
         zc = zc << 1;
      end
      if (total > 4 * UNIT - 1) total = 4 * UNIT - 1;
      if (total < -4 * UNIT) total = -4 * UNIT;
      return total[OUT_W-1:0];
   endfunction

   assign noise_pending = noise_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         octaves_shadow <= 4'd1;
         noise_queue.delete();
         fail_count <= 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_OCTAVE_COUNT)
            octaves_shadow <= csr_pwdata[CFG_W-1:0];
         // request beats
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_LOAD)
               perm_shadow[req_tdata[7:0]] = req_tdata[15:8];
            else
               noise_queue.push_back(octave_sum(req_tdata[39:16], req_tdata[63:40],
                                                req_tdata[87:64]));
         end
         // result beats
         if (rsp_tvalid && rsp_tready) begin
            if (noise_queue.size() == 0) begin
               $error("noise_value beat with no evaluate outstanding: %0d",
                      $signed(rsp_tdata[OUT_W-1:0]));
               fail_count <= fail_count + 1;
            end else begin
               logic signed [OUT_W-1:0] want;
               want = noise_queue.pop_front();
               if (rsp_tdata[OUT_W-1:0] !== want) begin
                  $error("noise_value expected %0d actual %0d", want,
                         $signed(rsp_tdata[OUT_W-1:0]));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the 3d octave noise block: loads the whole
// permutation table, then runs directed and random evaluate and load beats
// under several octave counts with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;
   import pn3_pkg::*;

   localparam int REG_SPARE = 1;     // no register lives here, writes are dropped
   localparam int IDLE_LIMIT = 5000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = REQ_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    noise_pending;
   int                    fail_count;
   int                    idle_cycles = 0;
   bit                    no_gaps = 1'b0;

   always #6 clock = ~clock;

   perlin_noise_3d_octaves dut (.*);

   noise_checker checker_i (.*);

   function automatic int draw_gap();
      return no_gaps ? 0 : int'($urandom_range(0, 14));
   endfunction

   // one request beat, valid held across back-to-back beats
   task automatic send_beat(input logic kind, input logic [7:0] idx, input logic [7:0] val,
                            input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = kind;
      req_tdata  = {z, y, x, val, idx};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic evaluate(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
      send_beat(REQ_EVAL, 8'($urandom), 8'($urandom), x, y, z);
   endtask

   task automatic csr_write(input int index, input logic [31:0] value);
      req_tvalid = 1'b0;
      // settle: results drained, then a wait for trailing loads
      while (noise_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(4 * index);
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return {8'($urandom_range(0, 255)), 16'h0000};
         3: return {8'($urandom_range(0, 255)), 16'hFFFF};
         default: return 24'($urandom);
      endcase
   endfunction

   // result side stalls
   initial begin
      forever begin
         int stall;
         @(negedge clock);
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("perlin_noise_3d_octaves: mismatch");
         $finish;
      end
   end

   initial begin
      logic [3:0] octave_plan [8];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // whole table first: extremes at both ends, random bytes elsewhere
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_beat(REQ_LOAD, 8'(i), (i == 0) ? 8'h00 : (i == 255) ? 8'hFF : 8'($urandom),
                   24'($urandom), 24'($urandom), 24'($urandom));

      // directed evaluates: lattice corners, wrap and fraction extremes
      csr_write(int'(CSR_OCTAVE_COUNT), 32'd8);
      evaluate(24'h000000, 24'h000000, 24'h000000);
      evaluate(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      evaluate(24'hFF0000, 24'h00FFFF, 24'h800000);
      evaluate(24'h00FFFF, 24'hFF0000, 24'hFFFFFF);
      evaluate(24'h008000, 24'h008000, 24'h008000);
      evaluate(24'h000001, 24'hFFFFFE, 24'h7FFFFF);
      evaluate(24'hAAAAAA, 24'h555555, 24'hF0F0F0);
      send_beat(REQ_LOAD, 8'd255, 8'd0, '0, '0, '0);
      send_beat(REQ_LOAD, 8'd0, 8'd255, '0, '0, '0);
      evaluate(24'hFF8000, 24'h000000, 24'hFF8000);
      // out of range counts clamp; spare register is ignored
      csr_write(int'(CSR_OCTAVE_COUNT), 32'd0);
      evaluate(24'h123456, 24'h654321, 24'hABCDEF);
      csr_write(int'(CSR_OCTAVE_COUNT), 32'hFFFF_FFFF);
      evaluate(24'h123456, 24'h654321, 24'hABCDEF);
      csr_write(REG_SPARE, 32'd2);
      evaluate(24'h123456, 24'h654321, 24'hABCDEF);

      // random phases across octave settings
      octave_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd9, 4'd1};
      foreach (octave_plan[p]) begin
         csr_write(int'(CSR_OCTAVE_COUNT),
                   (p == 4) ? 32'($urandom_range(2, 7)) : 32'(octave_plan[p]));
         no_gaps = (p % 3 == 2);
         for (int k = 0; k < 215; k++) begin
            if ($urandom_range(0, 99) < 15)
               send_beat(REQ_LOAD, 8'($urandom), 8'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom));
            else
               evaluate(rand_coord(), rand_coord(), rand_coord());
         end
         no_gaps = 1'b0;
      end
      req_tvalid = 1'b0;

      // drain
      while (noise_pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0 && noise_pending == 0)
         $display("perlin_noise_3d_octaves: match");
      else
         $display("perlin_noise_3d_octaves: mismatch");
      $finish;
   end

endmodule
